// ===== sv/mbrp_pkg.sv =====
// Types, character codes and event codes shared by the multibulk request parser.
// No dependencies.
package mbrp_pkg;

  localparam int BYTE_W  = 8;
  localparam int EVENT_W = 2;
  localparam int IDX_W   = 4;
  localparam int LIM_W   = 16;
  localparam int CMP_W   = 20;

  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

  localparam logic [LIM_W-1:0] MAX_LEN_RST = 16'd4096;

  localparam logic [EVENT_W-1:0] EV_BYTE = 2'd0;
  localparam logic [EVENT_W-1:0] EV_END  = 2'd1;
  localparam logic [EVENT_W-1:0] EV_ERR  = 2'd2;

  typedef enum logic [11:0] {
    PH_HDR_STAR   = 12'b0000_0000_0001,
    PH_HDR_DIGIT  = 12'b0000_0000_0010,
    PH_HDR_CR     = 12'b0000_0000_0100,
    PH_HDR_LF     = 12'b0000_0000_1000,
    PH_ARG_DOLLAR = 12'b0000_0001_0000,
    PH_ARG_FIRST  = 12'b0000_0010_0000,
    PH_ARG_DIGITS = 12'b0000_0100_0000,
    PH_ARG_LF     = 12'b0000_1000_0000,
    PH_PAYLOAD    = 12'b0001_0000_0000,
    PH_TRAIL1     = 12'b0010_0000_0000,
    PH_TRAIL2     = 12'b0100_0000_0000,
    PH_DEAD       = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    logic [EVENT_W-1:0] event_res;
    logic [BYTE_W-1:0]  payload_byte;
    logic [IDX_W-1:0]   arg_index;
    logic               request_done;
  } res_t;

  typedef struct packed {
    logic is_digit;
    logic over;
  } dig_stat_t;

endpackage

// ===== sv/mbrp_len_digit.sv =====
// Length digit unit: classifies a byte as a decimal digit and folds it into
// the declared length, flagging a value above the effective limit. Uses mbrp_pkg.
module mbrp_len_digit import mbrp_pkg::*; #(
  parameter int ACC_W = 16
) (
  input  logic [BYTE_W-1:0] data_byte,
  input  logic [ACC_W-1:0]  accum,
  input  logic [LIM_W-1:0]  max_len,
  output dig_stat_t         stat,
  output logic [ACC_W-1:0]  accum_nxt
);

  localparam logic [LIM_W-1:0] CAP = {LIM_W{1'b1}} >> (LIM_W - ACC_W);

  logic [ACC_W+3:0] wide;
  logic [LIM_W-1:0] lim;

  always_comb begin
    wide = {accum, 3'b000} + {2'b00, accum, 1'b0} + (ACC_W+4)'(data_byte[3:0]);
    lim  = (max_len > CAP) ? CAP : max_len;
    stat.is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    stat.over     = CMP_W'(wide) > CMP_W'(lim);
    accum_nxt     = wide[ACC_W-1:0];
  end

endmodule

// ===== sv/mbrp_fsm.sv =====
// Framing state machine: holds the parse phase, argument counters and length
// state, and forms at most one result per byte. Uses mbrp_pkg and mbrp_len_digit.
module mbrp_fsm import mbrp_pkg::*; #(
  parameter int ACC_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic [LIM_W-1:0]  max_len,
  output logic              res_vld,
  output res_t              res
);

  phase_t            phase_r, phase_nxt;
  logic [IDX_W-1:0]  total_r, total_nxt;
  logic [IDX_W-1:0]  count_r, count_nxt;
  logic [ACC_W-1:0]  accum_r, accum_nxt;
  logic [ACC_W-1:0]  left_r, left_nxt;
  logic [ACC_W-1:0]  dig_accum;
  dig_stat_t         dig;
  logic              err;
  logic              hdr;
  logic              done;

  mbrp_len_digit #(.ACC_W(ACC_W)) u_digit (
    .data_byte (data_byte),
    .accum     (accum_r),
    .max_len   (max_len),
    .stat      (dig),
    .accum_nxt (dig_accum)
  );

  always_comb begin
    phase_nxt = phase_r;
    total_nxt = total_r;
    count_nxt = count_r;
    accum_nxt = accum_r;
    left_nxt  = left_r;
    res_vld   = 1'b0;
    res       = '0;
    err       = 1'b0;
    done      = ({1'b0, count_r} + 5'd1) >= {1'b0, total_r};
    hdr       = (phase_r == PH_HDR_STAR) || (phase_r == PH_HDR_DIGIT) ||
                (phase_r == PH_HDR_CR) || (phase_r == PH_HDR_LF);
    case (phase_r)
      PH_HDR_STAR: begin
        if (data_byte != CH_STAR) err = 1'b1;
        else phase_nxt = PH_HDR_DIGIT;
      end
      PH_HDR_DIGIT: begin
        if (!dig.is_digit) err = 1'b1;
        else begin
          total_nxt = data_byte[IDX_W-1:0];
          phase_nxt = PH_HDR_CR;
        end
      end
      PH_HDR_CR: begin
        if (data_byte != CH_CR) err = 1'b1;
        else phase_nxt = PH_HDR_LF;
      end
      PH_HDR_LF: begin
        if (data_byte != CH_LF) err = 1'b1;
        else begin
          count_nxt = '0;
          phase_nxt = (total_r == '0) ? PH_HDR_STAR : PH_ARG_DOLLAR;
        end
      end
      PH_ARG_DOLLAR: begin
        if (data_byte != CH_DOLLAR) err = 1'b1;
        else begin
          accum_nxt = '0;
          phase_nxt = PH_ARG_FIRST;
        end
      end
      PH_ARG_FIRST: begin
        if (!dig.is_digit || dig.over) err = 1'b1;
        else begin
          accum_nxt = dig_accum;
          phase_nxt = PH_ARG_DIGITS;
        end
      end
      PH_ARG_DIGITS: begin
        if (dig.is_digit) begin
          if (dig.over) err = 1'b1;
          else accum_nxt = dig_accum;
        end else if (data_byte != CH_CR) begin
          err = 1'b1;
        end else begin
          phase_nxt = PH_ARG_LF;
        end
      end
      PH_ARG_LF: begin
        if (data_byte != CH_LF) err = 1'b1;
        else begin
          left_nxt  = accum_r;
          phase_nxt = (accum_r == '0) ? PH_TRAIL1 : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        left_nxt = left_r - ACC_W'(1);
        if (left_r == ACC_W'(1)) phase_nxt = PH_TRAIL1;
        res_vld          = 1'b1;
        res.event_res    = EV_BYTE;
        res.payload_byte = data_byte;
        res.arg_index    = count_r;
      end
      PH_TRAIL1: begin
        phase_nxt = PH_TRAIL2;
      end
      PH_TRAIL2: begin
        res_vld          = 1'b1;
        res.event_res    = EV_END;
        res.arg_index    = count_r;
        res.request_done = done;
        if (done) begin
          count_nxt = '0;
          phase_nxt = PH_HDR_STAR;
        end else begin
          count_nxt = count_r + IDX_W'(1);
          phase_nxt = PH_ARG_DOLLAR;
        end
      end
      PH_DEAD: begin
        phase_nxt = PH_DEAD;
      end
      default: begin
        phase_nxt = PH_DEAD;
      end
    endcase
    if (err) begin
      phase_nxt     = PH_DEAD;
      res_vld       = 1'b1;
      res           = '0;
      res.event_res = EV_ERR;
      res.arg_index = hdr ? '0 : count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR_STAR;
      total_r <= '0;
      count_r <= '0;
      accum_r <= '0;
      left_r  <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      total_r <= total_nxt;
      count_r <= count_nxt;
      accum_r <= accum_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

// ===== sv/multibulk_request_parser.sv =====
// Top level of the multibulk request parser: input register, framing state
// machine and result register, plus the length limit register. Uses mbrp_pkg, mbrp_fsm.
//
// Takes one stream byte per clock cycle with no bubbles while out_stall is low;
// each byte waits in the input register, is parsed by the framing state machine
// when it fires, and its result, if any, is captured in the result register.
// The rate is set by the state update in the framing state machine. No clearing pass
// follows reset. After a protocol error the block drops every byte until reset.
module multibulk_request_parser import mbrp_pkg::*; #(
  parameter int LEN_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BYTE_W-1:0]  in_data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [EVENT_W-1:0] out_event_res,
  output logic [BYTE_W-1:0]  out_payload_byte,
  output logic [IDX_W-1:0]   out_arg_index,
  output logic               out_request_done,
  input  logic               cfg_we,
  input  logic [LIM_W-1:0]   cfg_max_arg_len
);

  localparam int ACC_W = (LEN_BITS < LIM_W) ? LEN_BITS : LIM_W;

  logic              ivld_r;
  logic [BYTE_W-1:0] idata_r;
  logic              ovld_r;
  res_t              ores_r;
  logic [LIM_W-1:0]  max_len_r;
  logic              adv;
  logic              fire;
  logic              res_vld;
  res_t              res;

  assign adv      = !ovld_r || !out_stall;
  assign fire     = ivld_r && adv;
  assign in_stall = ivld_r && !adv;

  mbrp_fsm #(.ACC_W(ACC_W)) u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .data_byte (idata_r),
    .max_len   (max_len_r),
    .res_vld   (res_vld),
    .res       (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      ivld_r <= 1'b1;
    end else if (adv) begin
      ivld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) idata_r <= in_data_byte;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (fire) begin
      ovld_r <= res_vld;
    end else if (!out_stall) begin
      ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) ores_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_we) begin
      max_len_r <= cfg_max_arg_len;
    end
  end

  assign out_valid        = ovld_r;
  assign out_event_res    = ores_r.event_res;
  assign out_payload_byte = ores_r.payload_byte;
  assign out_arg_index    = ores_r.arg_index;
  assign out_request_done = ores_r.request_done;

endmodule

// ===== test/tb_multibulk_request_parser.sv =====
// Self-checking testbench for multibulk_request_parser: a byte driver, a result monitor
// and an in-bench predictor of the framing state machine and its length limit.
// Depends on mbrp_pkg and multibulk_request_parser.
module tb_multibulk_request_parser;
  import mbrp_pkg::*;

  typedef enum int {
    BRK_NONE, BRK_STAR, BRK_COUNT, BRK_HDR_CR, BRK_HDR_LF,
    BRK_DOLLAR, BRK_FIRST, BRK_DIGITS, BRK_ARG_LF, BRK_TOO_LONG
  } break_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 6;
  localparam int HOLD_CYCLES    = 300;

  logic               clk;
  logic               rst_n            = 1'b0;
  logic               in_valid         = 1'b0;
  logic               in_stall;
  logic [BYTE_W-1:0]  in_data_byte     = '0;
  logic               out_valid;
  logic               out_stall        = 1'b0;
  logic [EVENT_W-1:0] out_event_res;
  logic [BYTE_W-1:0]  out_payload_byte;
  logic [IDX_W-1:0]   out_arg_index;
  logic               out_request_done;
  logic               cfg_we           = 1'b0;
  logic [LIM_W-1:0]   cfg_max_arg_len  = MAX_LEN_RST;

  multibulk_request_parser u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_payload_byte (out_payload_byte),
    .out_arg_index    (out_arg_index),
    .out_request_done (out_request_done),
    .cfg_we           (cfg_we),
    .cfg_max_arg_len  (cfg_max_arg_len)
  );

  logic [BYTE_W-1:0] stream_q[$];
  res_t              expected_events[$];
  int                mismatches = 0;

  // parser model state
  phase_t            ph       = PH_HDR_STAR;
  logic [IDX_W-1:0]  n_total  = '0;
  logic [IDX_W-1:0]  n_done   = '0;
  int unsigned       len_acc  = 0;
  logic [16:0]       left     = '0;
  logic [LIM_W-1:0]  len_max  = MAX_LEN_RST;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_digit(logic [BYTE_W-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void push_event(logic [EVENT_W-1:0] ev, logic [BYTE_W-1:0] b,
                                     logic [IDX_W-1:0] idx, logic dn);
    res_t r;
    r.event_res    = ev;
    r.payload_byte = b;
    r.arg_index    = idx;
    r.request_done = dn;
    expected_events.push_back(r);
  endfunction

  function automatic void framing_error();
    // header errors carry index zero
    if (ph inside {PH_HDR_STAR, PH_HDR_DIGIT, PH_HDR_CR, PH_HDR_LF})
      push_event(EV_ERR, '0, '0, 1'b0);
    else
      push_event(EV_ERR, '0, n_done, 1'b0);
    ph = PH_DEAD;
  endfunction

  function automatic void take_digit(logic [BYTE_W-1:0] c);
    int unsigned v;
    v = len_acc * 10 + int'(c - CH_ZERO);
    if (v > int'(len_max)) begin
      framing_error();
    end else begin
      len_acc = v;
      ph = PH_ARG_DIGITS;
    end
  endfunction

  function automatic void parse_byte(logic [BYTE_W-1:0] c);
    logic dn;
    case (ph)
      PH_HDR_STAR: begin
        if (c != CH_STAR) framing_error();
        else ph = PH_HDR_DIGIT;
      end
      PH_HDR_DIGIT: begin
        if (!is_digit(c)) begin
          framing_error();
        end else begin
          n_total = IDX_W'(c - CH_ZERO);
          ph = PH_HDR_CR;
        end
      end
      PH_HDR_CR: begin
        if (c != CH_CR) framing_error();
        else ph = PH_HDR_LF;
      end
      PH_HDR_LF: begin
        if (c != CH_LF) begin
          framing_error();
        end else begin
          n_done = '0;
          ph = (n_total == '0) ? PH_HDR_STAR : PH_ARG_DOLLAR;
        end
      end
      PH_ARG_DOLLAR: begin
        if (c != CH_DOLLAR) begin
          framing_error();
        end else begin
          len_acc = 0;
          ph = PH_ARG_FIRST;
        end
      end
      PH_ARG_FIRST: begin
        if (!is_digit(c)) framing_error();
        else take_digit(c);
      end
      PH_ARG_DIGITS: begin
        if (is_digit(c)) take_digit(c);
        else if (c != CH_CR) framing_error();
        else ph = PH_ARG_LF;
      end
      PH_ARG_LF: begin
        if (c != CH_LF) begin
          framing_error();
        end else begin
          left = 17'(len_acc);
          ph = (left == '0) ? PH_TRAIL1 : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        left = left - 17'd1;
        if (left == '0) ph = PH_TRAIL1;
        push_event(EV_BYTE, c, n_done, 1'b0);
      end
      PH_TRAIL1: ph = PH_TRAIL2;
      PH_TRAIL2: begin
        dn = (int'(n_done) + 1 >= int'(n_total));
        push_event(EV_END, '0, n_done, dn);
        if (dn) begin
          n_done = '0;
          ph = PH_HDR_STAR;
        end else begin
          n_done = n_done + 1'b1;
          ph = PH_ARG_DOLLAR;
        end
      end
      default: ph = PH_DEAD;
    endcase
  endfunction

  // stimulus helpers
  function automatic logic [BYTE_W-1:0] pick_other(logic [BYTE_W-1:0] avoid, bit no_digit,
                                                   bit no_cr);
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255));
    while (b == avoid || (no_digit && is_digit(b)) || (no_cr && b == CH_CR));
    return b;
  endfunction

  function automatic int pick_len();
    int lim;
    int cap;
    lim = int'(len_max);
    if (lim <= 60 && $urandom_range(0, 7) == 0) return lim;
    cap = (lim < 12) ? lim : 12;
    if ($urandom_range(0, 15) == 0) cap = (lim < 60) ? lim : 60;
    return $urandom_range(0, cap);
  endfunction

  task automatic push_len(int v, int zeros);
    int digs[$];
    repeat (zeros) stream_q.push_back(CH_ZERO);
    do begin
      digs.push_front(v % 10);
      v = v / 10;
    end while (v > 0);
    foreach (digs[i]) stream_q.push_back(CH_ZERO + BYTE_W'(digs[i]));
  endtask

  task automatic add_request(int nargs, break_t brk);
    int bad_arg;
    int n;
    int zeros;
    bit hit;
    bad_arg = (nargs > 0) ? $urandom_range(0, nargs - 1) : 0;
    if (brk == BRK_STAR) begin
      stream_q.push_back(pick_other(CH_STAR, 0, 0));
      return;
    end
    stream_q.push_back(CH_STAR);
    if (brk == BRK_COUNT) begin
      stream_q.push_back(pick_other(CH_ZERO, 1, 0));
      return;
    end
    stream_q.push_back(CH_ZERO + BYTE_W'(nargs));
    if (brk == BRK_HDR_CR) begin
      stream_q.push_back(pick_other(CH_CR, 0, 0));
      return;
    end
    stream_q.push_back(CH_CR);
    if (brk == BRK_HDR_LF) begin
      stream_q.push_back(pick_other(CH_LF, 0, 0));
      return;
    end
    stream_q.push_back(CH_LF);
    for (int a = 0; a < nargs; a++) begin
      hit = (a == bad_arg);
      if (hit && brk == BRK_DOLLAR) begin
        stream_q.push_back(pick_other(CH_DOLLAR, 0, 0));
        return;
      end
      stream_q.push_back(CH_DOLLAR);
      if (hit && brk == BRK_FIRST) begin
        stream_q.push_back(pick_other(CH_ZERO, 1, 0));
        return;
      end
      zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      if (hit && brk == BRK_TOO_LONG) begin
        push_len(int'(len_max) + 1 + $urandom_range(0, 3), zeros);
        return;
      end
      n = pick_len();
      push_len(n, zeros);
      if (hit && brk == BRK_DIGITS) begin
        stream_q.push_back(pick_other(CH_CR, 1, 1));
        return;
      end
      stream_q.push_back(CH_CR);
      if (hit && brk == BRK_ARG_LF) begin
        stream_q.push_back(pick_other(CH_LF, 0, 0));
        return;
      end
      stream_q.push_back(CH_LF);
      repeat (n) stream_q.push_back(BYTE_W'($urandom_range(0, 255)));
      repeat (2) stream_q.push_back(BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic fill_requests(int count);
    while (stream_q.size() < count) add_request($urandom_range(0, 9), BRK_NONE);
  endtask

  // wait until every request is taken and every result is back
  task automatic settle();
    @(negedge clk);
    while (stream_q.size() != 0 || in_valid || expected_events.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(logic [LIM_W-1:0] v);
    settle();
    @(posedge clk);
    cfg_we          <= 1'b1;
    cfg_max_arg_len <= v;
    len_max = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sender: bursts and gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_data_byte <= '0;
      burst_left   <= 0;
      gap_left     <= 0;
    end else begin
      if (in_valid && !in_stall) parse_byte(in_data_byte);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (stream_q.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          in_valid     <= 1'b1;
          in_data_byte <= stream_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 30);
            gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(4, 16)
                                                     : $urandom_range(0, 3);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver: stall modes plus one long hold-off
  logic       hold_req   = 1'b0;
  logic       hold_done  = 1'b0;
  int         hold_left  = 0;
  int         mode_left  = 0;
  logic [1:0] stall_mode = '0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= 2'($urandom_range(0, 3));
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(0, 3) == 0);
        2'd2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // result monitor
  res_t want;

  function automatic void check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        $display("%0t unexpected result: event %0d byte %0d index %0d done %0d", $time,
                 out_event_res, out_payload_byte, out_arg_index, out_request_done);
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        check_field("event_res", want.event_res, out_event_res);
        check_field("payload_byte", want.payload_byte, out_payload_byte);
        check_field("arg_index", want.arg_index, out_arg_index);
        check_field("request_done", want.request_done, out_request_done);
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero count, zero length, two-byte argument with leading zero and extreme bytes
    stream_q = '{CH_STAR, CH_ZERO, CH_CR, CH_LF,
                 CH_STAR, CH_ZERO + 8'd2, CH_CR, CH_LF,
                 CH_DOLLAR, CH_ZERO, CH_CR, CH_LF, CH_CR, CH_LF,
                 CH_DOLLAR, CH_ZERO, CH_ZERO + 8'd2, CH_CR, CH_LF,
                 8'h00, 8'hFF, 8'hFF, 8'h00};
    settle();
    fill_requests(280);

    set_limit('0);
    fill_requests(200);

    set_limit('1);
    hold_req <= 1'b1;
    fill_requests(300);

    set_limit(LIM_W'(5));
    fill_requests(280);

    set_limit(LIM_W'($urandom_range(0, 65535)));
    fill_requests(280);

    set_limit(LIM_W'($urandom_range(1, 20)));
    fill_requests(280);

    // one broken request at the end, then bytes that must be dropped
    settle();
    repeat ($urandom_range(0, 2)) add_request($urandom_range(0, 9), BRK_NONE);
    add_request($urandom_range(1, 9), break_t'($urandom_range(BRK_STAR, BRK_TOO_LONG)));
    repeat (16) stream_q.push_back(BYTE_W'($urandom_range(0, 255)));
    settle();

    if (mismatches == 0 && expected_events.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
